>>> rtl/smf_pkg.sv
`default_nettype none

package smf_pkg;

    // sample format, fixed by the stream
    localparam int SAMPLE_WIDTH = 16;

    // default largest half width of the window
    localparam int MAX_HALF_DEF = 3;

    // window_half register
    localparam int HALF_WIDTH = 2;
    localparam logic [HALF_WIDTH-1:0] HALF_RESET = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           last_in;
    } smf_in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] filtered_sample;
        logic                           last_out;
    } smf_out_t;

endpackage

`default_nettype wire

>>> rtl/smf_median.sv
`default_nettype none

module smf_median #(
    parameter int MAX_HALF = smf_pkg::MAX_HALF_DEF,
    localparam int HIST = 2 * MAX_HALF + 1,
    localparam int AW   = $clog2(MAX_HALF + 1),
    localparam int CW   = $clog2(HIST + 1),
    localparam int KW   = $clog2(HIST)
) (
    input  var logic signed [smf_pkg::SAMPLE_WIDTH-1:0] hist_i [HIST],
    input  var logic [AW-1:0]                           age_i,
    input  var logic [AW-1:0]                           half_i,
    input  var logic [CW-1:0]                           count_i,
    output var logic signed [smf_pkg::SAMPLE_WIDTH-1:0] median_o
);

    logic [KW-1:0]   lo;
    logic [KW-1:0]   hi;
    logic [KW-1:0]   hi_sum;
    logic [KW-1:0]   hi_cnt;
    logic [HIST-1:0] mask;
    logic [CW-1:0]   n;
    logic [CW-1:0]   target;
    logic [CW-1:0]   rank [HIST];

    // window bounds, cut to the samples of the current signal
    always_comb begin
        lo     = (age_i > half_i) ? KW'(age_i - half_i) : '0;
        hi_sum = KW'(age_i) + KW'(half_i);
        hi_cnt = KW'(count_i - 1'b1);
        hi     = (hi_sum < hi_cnt) ? hi_sum : hi_cnt;
        for (int k = 0; k < HIST; k++) begin
            mask[k] = (KW'(k) >= lo) && (KW'(k) <= hi);
        end
        n      = CW'($countones(mask));
        target = n >> 1;
    end

    // rank of each entry among the window, ties broken by position
    always_comb begin
        median_o = '0;
        for (int i = 0; i < HIST; i++) begin
            rank[i] = '0;
            for (int j = 0; j < HIST; j++) begin
                if (mask[j] && ((hist_i[j] < hist_i[i]) ||
                                ((hist_i[j] == hist_i[i]) && (j < i)))) begin
                    rank[i] = rank[i] + 1'b1;
                end
            end
        end
        for (int i = 0; i < HIST; i++) begin
            if (mask[i] && (rank[i] == target)) begin
                median_o = median_o | hist_i[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/sliding_median_filter.sv
// sliding median filter with truncated window edges
//
// input request (s_valid/s_ready/s_data) carries one signed sample and a
// last-of-signal mark. result request (m_valid/m_ready/m_data) carries the
// median of the window around the output position, lagging the input by
// window_half samples. at the start and end of a signal the window shrinks
// to the samples that exist; an even count takes the upper median.
// an accepted sample may start a job in the job register; its result moves into
// the output register once that is free. throughput: one sample per cycle unless
// stalled or flushing, set by the single rank-compare network between the two
// registers. a sample marked last flushes every pending position, oldest first,
// up to window_half+1 results, one per cycle unless stalled; s_ready stays low
// until the final one moves into the output register, then the block starts a
// new signal. when the receiver stalls, the output register holds its result and
// the block takes one more sample into the job register before s_ready drops.
// reset (aresetn low, synchronous) empties both registers, clears the
// sample count and sets window_half to 2. cfg_wr_en writes window_half;
// change it only while the block is idle. values above MAX_HALF act as MAX_HALF.

`default_nettype none

module sliding_median_filter #(
    parameter int MAX_HALF = smf_pkg::MAX_HALF_DEF
) (
    input  var logic                             aclk,
    input  var logic                             aresetn,
    input  var logic                             s_valid,
    output var logic                             s_ready,
    input  var smf_pkg::smf_in_t                 s_data,
    output var logic                             m_valid,
    input  var logic                             m_ready,
    output var smf_pkg::smf_out_t                m_data,
    input  var logic                             cfg_wr_en,
    input  var logic [smf_pkg::HALF_WIDTH-1:0]   cfg_wr_data
);

    localparam int HIST = 2 * MAX_HALF + 1;
    localparam int AW   = $clog2(MAX_HALF + 1);
    localparam int CW   = $clog2(HIST + 1);

    // configuration
    logic [smf_pkg::HALF_WIDTH-1:0] window_half_reg;
    logic [AW-1:0]                  half_eff;

    // sample history, newest at index 0
    logic signed [smf_pkg::SAMPLE_WIDTH-1:0] hist_reg  [HIST];
    logic signed [smf_pkg::SAMPLE_WIDTH-1:0] hist_next [HIST];
    logic [CW-1:0] count_reg, count_next, count_inc;

    // job register: which position to emit next
    logic          job_valid_reg, job_valid_next;
    logic          job_flush_reg, job_flush_next;
    logic [AW-1:0] job_age_reg, job_age_next;
    logic [AW-1:0] job_half_reg, job_half_next;
    logic [CW-1:0] job_count_reg, job_count_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    smf_pkg::smf_out_t m_data_reg, m_data_next;

    logic accept;
    logic out_free;
    logic job_advance;
    logic job_done;
    logic signed [smf_pkg::SAMPLE_WIDTH-1:0] median;

    // clamp the register to the history depth
    assign half_eff = (int'(window_half_reg) > MAX_HALF) ? AW'(MAX_HALF)
                                                         : AW'(window_half_reg);

    assign out_free    = !m_valid_reg || m_ready;
    assign job_advance = job_valid_reg && out_free;
    // a flush job keeps going until the newest position is out
    assign job_done    = !job_flush_reg || (job_age_reg == '0);
    // history is frozen while a flush still needs it
    assign s_ready     = !job_valid_reg || (job_advance && job_done);
    assign accept      = s_valid && s_ready;

    assign count_inc = (count_reg < CW'(HIST)) ? count_reg + 1'b1 : count_reg;

    smf_median #(
        .MAX_HALF (MAX_HALF)
    ) u_median (
        .hist_i   (hist_reg),
        .age_i    (job_age_reg),
        .half_i   (job_half_reg),
        .count_i  (job_count_reg),
        .median_o (median)
    );

    always_comb begin
        hist_next      = hist_reg;
        count_next     = count_reg;
        job_valid_next = job_valid_reg;
        job_flush_next = job_flush_reg;
        job_age_next   = job_age_reg;
        job_half_next  = job_half_reg;
        job_count_next = job_count_reg;

        // retire or step the current job
        if (job_advance) begin
            if (job_done) begin
                job_valid_next = 1'b0;
            end else begin
                job_age_next = job_age_reg - 1'b1;
            end
        end

        // new sample: shift it in and set up its job
        if (accept) begin
            hist_next[0] = s_data.sample;
            for (int k = 1; k < HIST; k++) begin
                hist_next[k] = hist_reg[k-1];
            end
            job_half_next  = half_eff;
            job_count_next = count_inc;
            if (s_data.last_in) begin
                job_valid_next = 1'b1;
                job_flush_next = 1'b1;
                job_age_next   = (CW'(half_eff) < count_inc - 1'b1) ? half_eff
                                                                    : AW'(count_inc - 1'b1);
                count_next     = '0;
            end else begin
                // position half samples back exists once half+1 samples are in
                job_valid_next = (count_inc > CW'(half_eff));
                job_flush_next = 1'b0;
                job_age_next   = half_eff;
                count_next     = count_inc;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (job_advance) begin
            m_valid_next                = 1'b1;
            m_data_next.filtered_sample = median;
            m_data_next.last_out        = job_flush_reg && (job_age_reg == '0);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_half_reg <= smf_pkg::HALF_RESET;
            count_reg       <= '0;
            job_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                window_half_reg <= cfg_wr_data;
            end
            count_reg     <= count_next;
            job_valid_reg <= job_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        hist_reg      <= hist_next;
        job_flush_reg <= job_flush_next;
        job_age_reg   <= job_age_next;
        job_half_reg  <= job_half_next;
        job_count_reg <= job_count_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

>>> rtl/smf_checker.sv
`default_nettype none

module smf_checker (
    input var logic              aclk,
    input var logic              aresetn,
    input var logic              s_valid,
    input var logic              s_ready,
    input var smf_pkg::smf_in_t  s_data,
    input var logic              m_valid,
    input var logic              m_ready,
    input var smf_pkg::smf_out_t m_data
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // reset leaves the block ready for a new signal
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // an accepted last sample is always followed by a valid result at the output
    a_last_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last_in |-> ##2 m_valid)
        else $error("no result after last sample");

endmodule

bind sliding_median_filter smf_checker u_smf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int SAMPLE_WIDTH = smf_pkg::SAMPLE_WIDTH;
    localparam int HALF_WIDTH   = smf_pkg::HALF_WIDTH;
    localparam int HIST_DEPTH   = 2 * smf_pkg::MAX_HALF_DEF + 1;
    localparam int RANDOM_ITEMS = 126;
    // results pass the job and output registers after the sample, leave some margin
    localparam int DRAIN_CYCLES = 8;

    // one row of the directed table; known rows carry a hand-typed median
    typedef struct packed {
        logic                           wr_half;
        logic [HALF_WIDTH-1:0]          half;
        int                             sample;
        logic                           last;
        logic                           known;
        int                             known_val;
    } dir_row_t;

    typedef enum int unsigned {RX_STREAM, RX_RANDOM, RX_BURSTY} rx_mode_t;
    typedef enum int unsigned {VAL_FULL, VAL_NARROW, VAL_EXTREME, VAL_RAMP} val_style_t;

    localparam dir_row_t DIR_ROWS [24] = '{
        // reset half width, one-sample signal is its own median
        '{1'b0, 2'd2, -32768, 1'b1, 1'b1, -32768},
        // half 0: every median is the sample itself
        '{1'b1, 2'd0,  32767, 1'b0, 1'b1,  32767},
        '{1'b0, 2'd0,     -1, 1'b0, 1'b1,     -1},
        '{1'b0, 2'd0, -32768, 1'b1, 1'b1, -32768},
        // widest window with extremes, upper median on even counts at the edges
        '{1'b1, 2'd3,  32767, 1'b0, 1'b0, 0},
        '{1'b0, 2'd3, -32768, 1'b0, 1'b0, 0},
        '{1'b0, 2'd3,      0, 1'b0, 1'b0, 0},
        '{1'b0, 2'd3,     -1, 1'b0, 1'b0, 0},
        '{1'b0, 2'd3,      1, 1'b0, 1'b0, 0},
        '{1'b0, 2'd3,  21845, 1'b0, 1'b0, 0},
        '{1'b0, 2'd3, -21846, 1'b0, 1'b0, 0},
        '{1'b0, 2'd3,    100, 1'b0, 1'b0, 0},
        '{1'b0, 2'd3,   -100, 1'b1, 1'b0, 0},
        // signal shorter than the half width
        '{1'b0, 2'd3,      7, 1'b0, 1'b0, 0},
        '{1'b0, 2'd3,     -7, 1'b1, 1'b0, 0},
        // half 1 with duplicates
        '{1'b1, 2'd1,      5, 1'b0, 1'b0, 0},
        '{1'b0, 2'd1,     -5, 1'b0, 1'b0, 0},
        '{1'b0, 2'd1,      3, 1'b0, 1'b0, 0},
        '{1'b0, 2'd1,      3, 1'b1, 1'b0, 0},
        // half width changed in the middle of a signal
        '{1'b0, 2'd1,     10, 1'b0, 1'b0, 0},
        '{1'b0, 2'd1,     20, 1'b0, 1'b0, 0},
        '{1'b1, 2'd3,    -30, 1'b0, 1'b0, 0},
        '{1'b0, 2'd3,     40, 1'b0, 1'b0, 0},
        '{1'b1, 2'd0,    -50, 1'b1, 1'b0, 0}
    };

    // clock, reset and block inputs, all known from time zero
    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    smf_pkg::smf_in_t      s_data      = '0;
    logic                  m_ready     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [HALF_WIDTH-1:0] cfg_wr_data = '0;
    logic                  s_ready;
    logic                  m_valid;
    smf_pkg::smf_out_t     m_data;

    always #4 aclk = ~aclk;

    sliding_median_filter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // predictor state: sample history newest first, samples in this signal, half width
    logic signed [SAMPLE_WIDTH-1:0] hist_model [HIST_DEPTH];
    int unsigned                    count_model = 0;
    logic [HALF_WIDTH-1:0]          half_model  = smf_pkg::HALF_RESET;
    smf_pkg::smf_out_t              step_medians [$];
    smf_pkg::smf_out_t              pending_medians [$];

    int unsigned mismatch_count = 0;
    int unsigned checked_count  = 0;
    int unsigned requests_sent  = 0;
    int unsigned signals_sent   = 0;
    int unsigned burst_left     = 0;
    bit          halves_used [4] = '{1'b0, 1'b0, 1'b1, 1'b0};

    initial begin
        foreach (hist_model[i]) hist_model[i] = '0;
    end

    // median of the truncated window around the position age samples back
    function automatic logic signed [SAMPLE_WIDTH-1:0] median_of_window(
        int unsigned age, int unsigned half);
        logic signed [SAMPLE_WIDTH-1:0] win [HIST_DEPTH];
        logic signed [SAMPLE_WIDTH-1:0] key;
        int unsigned lo, hi, n, j;
        lo = (age > half) ? age - half : 0;
        hi = age + half;
        if (hi > count_model - 1) hi = count_model - 1;
        if (hi > HIST_DEPTH - 1) hi = HIST_DEPTH - 1;
        n = 0;
        for (int unsigned k = lo; k <= hi; k++) begin
            win[n] = hist_model[k];
            n++;
        end
        // insertion sort, signed compare
        for (int unsigned i = 1; i < n; i++) begin
            key = win[i];
            j = i;
            while (j > 0 && win[j-1] > key) begin
                win[j] = win[j-1];
                j--;
            end
            win[j] = key;
        end
        return win[n/2];
    endfunction

    // shift in one sample and collect the medians it releases
    function automatic void filter_step(smf_pkg::smf_in_t req);
        int unsigned half;
        int          age;
        half = int'(half_model);
        step_medians.delete();
        for (int k = HIST_DEPTH - 1; k > 0; k--) hist_model[k] = hist_model[k-1];
        hist_model[0] = req.sample;
        if (count_model < HIST_DEPTH) count_model++;
        if (!req.last_in) begin
            // steady state: the position half samples back is complete
            if (count_model >= half + 1)
                step_medians.push_back('{median_of_window(half, half), 1'b0});
        end else begin
            // last sample flushes every pending position, oldest first
            age = (half < count_model - 1) ? half : count_model - 1;
            for (int a = age; a >= 0; a--)
                step_medians.push_back('{median_of_window(a, half), a == 0});
            count_model = 0;
        end
    endfunction

    // one request on the input channel, prediction taken at acceptance
    task automatic send_request(input smf_pkg::smf_in_t req, input bit typed_known,
                                input smf_pkg::smf_out_t typed_val);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        filter_step(req);
        if (typed_known) pending_medians.push_back(typed_val);
        else foreach (step_medians[i]) pending_medians.push_back(step_medians[i]);
    endtask

    // bursts of random length with random gaps; now and then a long burst
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    // hold off until every median is out, then let the pipeline settle
    task automatic drain_filter();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_medians.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_half(input logic [HALF_WIDTH-1:0] half);
        drain_filter();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= half;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        half_model = half;
        halves_used[half] = 1'b1;
    endtask

    // receiver stalls: streaming, random, or bursty with long holds
    rx_mode_t    rx_mode    = RX_STREAM;
    int unsigned rx_left    = 0;
    int unsigned stall_left = 0;

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(20, 120);
        end else begin
            rx_left--;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STREAM: m_ready <= 1'b1;
                RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(4, 20);
                    m_ready <= (stall_left == 0);
                end
            endcase
        end
    end

    // result checker: oldest expectation against each accepted result
    always @(posedge aclk) begin
        smf_pkg::smf_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_medians.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: median %0d last %0b",
                             m_data.filtered_sample, m_data.last_out);
            end else begin
                want = pending_medians.pop_front();
                checked_count++;
                if (m_data.filtered_sample !== want.filtered_sample ||
                    m_data.last_out !== want.last_out) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch #%0d: expected median %0d last %0b, got %0d last %0b",
                                 checked_count, want.filtered_sample, want.last_out,
                                 m_data.filtered_sample, m_data.last_out);
                end
            end
        end
    end

    // reset held from time zero, released on a falling edge
    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // hard limit on the run
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        dir_row_t                       row;
        smf_pkg::smf_in_t               req;
        val_style_t                     style;
        logic signed [SAMPLE_WIDTH-1:0] ramp;
        int                             narrow;
        int unsigned                    sig_len;
        int unsigned                    rand_items;

        wait (aresetn === 1'b1);

        // directed table
        foreach (DIR_ROWS[i]) begin
            row = DIR_ROWS[i];
            if (row.wr_half) write_half(row.half);
            pace_sender();
            req.sample  = SAMPLE_WIDTH'(row.sample);
            req.last_in = row.last;
            send_request(req, row.known, '{SAMPLE_WIDTH'(row.known_val), row.last});
            if (row.last) signals_sent++;
        end

        // random signals, half width changed only at signal boundaries
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) write_half(HALF_WIDTH'($urandom_range(0, 3)));
            else if ($urandom_range(0, 7) == 0) drain_filter();
            sig_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 14);
            style = val_style_t'($urandom_range(0, 3));
            ramp  = SAMPLE_WIDTH'($urandom);
            for (int unsigned k = 0; k < sig_len; k++) begin
                case (style)
                    VAL_FULL: req.sample = SAMPLE_WIDTH'($urandom);
                    VAL_NARROW: begin
                        // small range so windows hold ties
                        narrow = $urandom_range(0, 8);
                        req.sample = SAMPLE_WIDTH'(narrow - 4);
                    end
                    VAL_EXTREME: begin
                        case ($urandom_range(0, 3))
                            0:       req.sample = 16'sh7fff;
                            1:       req.sample = 16'sh8000;
                            2:       req.sample = '0;
                            default: req.sample = '1;
                        endcase
                    end
                    default: begin
                        ramp = ramp + SAMPLE_WIDTH'($urandom_range(0, 500));
                        req.sample = ramp;
                    end
                endcase
                req.last_in = (k == sig_len - 1);
                pace_sender();
                send_request(req, 1'b0, '0);
                rand_items++;
            end
            signals_sent++;
        end

        drain_filter();

        $display("covered %0d requests in %0d signals, %0d medians checked",
                 requests_sent, signals_sent, checked_count);
        $display("window half widths used: 0=%0b 1=%0b 2=%0b 3=%0b",
                 halves_used[0], halves_used[1], halves_used[2], halves_used[3]);
        if (mismatch_count == 0 && pending_medians.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/smf_pkg.sv
rtl/smf_median.sv
rtl/sliding_median_filter.sv
rtl/smf_checker.sv
tb/tb_top.sv
